// File: hdl/wbsm_pkg.sv
// Package for the wildcard byte signature matcher.
// Types, constants and register codes shared by the RTL files.
`timescale 1ns / 1ps
package wbsm_pkg;

  localparam int unsigned MaxPatternBytes = 16;
  localparam int unsigned WinIdxW = $clog2(MaxPatternBytes);
  localparam int unsigned CntW = $clog2(MaxPatternBytes + 1);
  localparam int unsigned LenW = 5;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [7:0] byte_t;
  typedef logic [MaxPatternBytes-1:0][7:0] win_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_WILDCARD     = 2'd2,
    CFG_LENGTH       = 2'd3
  } cfg_idx_e;

  // Signature settings handed to the compare logic.
  typedef struct packed {
    win_t                       sig;
    logic [MaxPatternBytes-1:0] mask;
    cnt_t                       len;
  } sig_cfg_t;

endpackage

// File: hdl/wbsm_if.sv
// Channel interfaces of the wildcard byte signature matcher.
// Depends on wbsm_pkg.
`timescale 1ns / 1ps
interface wbsm_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbsm_out_if;
  logic valid;
  logic ready;
  logic match_ends_here;
  logic found;
  logic buffer_end;
  modport source (output valid, output match_ends_here, output found, output buffer_end,
                  input ready);
  modport sink (input valid, input match_ends_here, input found, input buffer_end,
                output ready);
endinterface

interface wbsm_cfg_if;
  logic valid;
  logic ready;
  logic [wbsm_pkg::CfgIdxW-1:0] index;
  logic [wbsm_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/wbsm_match.sv
// Wildcard compare of the signature against the byte window.
// Depends on wbsm_pkg.
`timescale 1ns / 1ps
module wbsm_match (
  input  wbsm_pkg::sig_cfg_t cfg_i,
  input  wbsm_pkg::win_t     win_i,
  input  wbsm_pkg::cnt_t     seen_i,
  output logic               match_o
);

  logic [wbsm_pkg::MaxPatternBytes-1:0] ok;

  always_comb begin
    for (int k = 0; k < int'(wbsm_pkg::MaxPatternBytes); k++) begin
      logic [wbsm_pkg::CntW-1:0] pos;
      pos = cfg_i.len - wbsm_pkg::CntW'(1) - wbsm_pkg::CntW'(k);
      ok[k] = (wbsm_pkg::CntW'(k) >= cfg_i.len) || cfg_i.mask[k] ||
              (cfg_i.sig[k] == win_i[pos[wbsm_pkg::WinIdxW-1:0]]);
    end
    match_o = (seen_i >= cfg_i.len) && (&ok);
  end

endmodule

// File: hdl/wildcard_byte_signature_match_core.sv
// Top level of the wildcard byte signature matcher.
// Depends on wbsm_pkg, wbsm_if and wbsm_match.
`timescale 1ns / 1ps
// Usage:
//   in_i carries one buffer byte per transfer, last_byte marking the final one.
//   out_o returns one result per byte: match_ends_here, found (sticky within the
//   buffer) and buffer_end (the echoed last_byte; found is then the verdict).
//   cfg_i writes pattern_low, pattern_high, wildcard_mask and pattern_length by
//   index; it is always ready and must be written only while the block is idle.
//   Flow: a byte taken from in_i is staged in the input register, and its
//   result shows on out_o from the result register.
//   Throughput: one byte per cycle while out_o does not stall.
//   The window update and the 16-way byte compare form the single step
//   between the two registers.
//   When out_o stalls, the result register holds, the staged byte waits, and
//   in_i.ready drops once both are full; nothing is lost or repeated.
//   Reset clears the window, the byte count, the found flag and the valid bits,
//   and returns the registers to zero with a pattern length of one.
//   After the last byte the window, count and flag clear; the registers keep.
module wildcard_byte_signature_match_core (
  input  logic clk_i,
  input  logic rst_ni,
  wbsm_in_if.sink    in_i,
  wbsm_out_if.source out_o,
  wbsm_cfg_if.sink   cfg_i
);

  logic [63:0] pat_low_q, pat_high_q;
  logic [15:0] mask_q;
  logic [wbsm_pkg::LenW-1:0] len_q;

  logic in_v_q;
  wbsm_pkg::byte_t in_byte_q;
  logic in_last_q;

  wbsm_pkg::win_t win_q, win_d, win_new;
  wbsm_pkg::cnt_t seen_q, seen_d, seen_new;
  logic found_q, found_d;

  logic out_v_q, out_match_q, out_found_q, out_end_q;

  logic advance, match;
  wbsm_pkg::sig_cfg_t sig_cfg;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      mask_q     <= '0;
      len_q      <= wbsm_pkg::LenW'(1);
    end else if (cfg_i.valid) begin
      unique case (wbsm_pkg::cfg_idx_e'(cfg_i.index))
        wbsm_pkg::CFG_PATTERN_LOW:  pat_low_q  <= cfg_i.data;
        wbsm_pkg::CFG_PATTERN_HIGH: pat_high_q <= cfg_i.data;
        wbsm_pkg::CFG_WILDCARD:     mask_q     <= cfg_i.data[15:0];
        wbsm_pkg::CFG_LENGTH:       len_q      <= cfg_i.data[wbsm_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Effective length: zero reads as one, anything above the window is clamped.
  always_comb begin
    sig_cfg.sig  = wbsm_pkg::win_t'({pat_high_q, pat_low_q});
    sig_cfg.mask = mask_q;
    if (len_q == '0) begin
      sig_cfg.len = wbsm_pkg::CntW'(1);
    end else if (len_q > wbsm_pkg::LenW'(wbsm_pkg::MaxPatternBytes)) begin
      sig_cfg.len = wbsm_pkg::CntW'(wbsm_pkg::MaxPatternBytes);
    end else begin
      sig_cfg.len = wbsm_pkg::CntW'(len_q);
    end
  end

  assign advance    = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || advance;

  always_comb begin
    win_new = {win_q[wbsm_pkg::MaxPatternBytes-2:0], in_byte_q};
    seen_new = (seen_q < wbsm_pkg::CntW'(wbsm_pkg::MaxPatternBytes)) ?
               seen_q + wbsm_pkg::CntW'(1) : seen_q;
    win_d   = win_q;
    seen_d  = seen_q;
    found_d = found_q;
    if (advance) begin
      if (in_last_q) begin
        win_d   = '0;
        seen_d  = '0;
        found_d = 1'b0;
      end else begin
        win_d   = win_new;
        seen_d  = seen_new;
        found_d = found_q | match;
      end
    end
  end

  wbsm_match u_match (
    .cfg_i   (sig_cfg),
    .win_i   (win_new),
    .seen_i  (seen_new),
    .match_o (match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      win_q   <= '0;
      seen_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_v_q <= in_i.valid;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      win_q   <= win_d;
      seen_q  <= seen_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
    if (advance) begin
      out_match_q <= match;
      out_found_q <= found_q | match;
      out_end_q   <= in_last_q;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.match_ends_here = out_match_q;
  assign out_o.found           = out_found_q;
  assign out_o.buffer_end      = out_end_q;

endmodule

// File: hdl/wbsm_checker.sv
// Port-level checks for the wildcard byte signature matcher, bound to the top.
// Depends on wildcard_byte_signature_match_core and wbsm_if.
`timescale 1ns / 1ps
module wbsm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_match,
  input logic out_found,
  input logic out_end,
  input logic cfg_ready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_match) && $stable(out_found) &&
                                $stable(out_end))
    else $error("result changed while stalled");

  a_match_sets_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_match |-> out_found)
    else $error("match reported without found");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind wildcard_byte_signature_match_core wbsm_checker u_wbsm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_match (out_o.match_ends_here),
  .out_found (out_o.found),
  .out_end   (out_o.buffer_end),
  .cfg_ready (cfg_i.ready)
);

// File: test/wbsm_match_checker.sv
`timescale 1ns / 1ps
// Checker for the wildcard byte signature matcher: mirrors the signature
// registers, the byte window and the found flag, and compares every result.
// Depends on wbsm_pkg and the channel interfaces in wbsm_if.
module wbsm_match_checker
  import wbsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wbsm_in_if          in_i,
  wbsm_out_if         res_i,
  wbsm_cfg_if         cfg_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned hits_o
);

  typedef struct packed {
    logic hit;
    logic found;
    logic last;
  } scan_result_t;

  scan_result_t expected_results[$];

  logic [CfgDataW-1:0]        sig_lo;
  logic [CfgDataW-1:0]        sig_hi;
  logic [MaxPatternBytes-1:0] wild;
  logic [LenW-1:0]            plen;
  win_t                       window;
  cnt_t                       seen;
  logic                       found_q;

  task automatic predict_match(input byte_t b, input logic last);
    int unsigned    len;
    logic           hit;
    logic [127:0]   sig;
    scan_result_t   r;
    len = plen;
    if (len < 1) len = 1;
    if (len > MaxPatternBytes) len = MaxPatternBytes;
    window = {window[MaxPatternBytes-2:0], b};
    if (seen < MaxPatternBytes) seen++;
    sig = {sig_hi, sig_lo};
    hit = (seen >= len);
    for (int k = 0; k < len; k++) begin
      if (!wild[k] && sig[8*k +: 8] != window[len-1-k]) hit = 1'b0;
    end
    found_q = found_q | hit;
    if (hit) hits_o++;
    r.hit   = hit;
    r.found = found_q;
    r.last  = last;
    expected_results.push_back(r);
    if (last) begin
      window  = '0;
      seen    = '0;
      found_q = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s expected %0b, got %0b", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    if (!rst_ni) begin
      sig_lo  = '0;
      sig_hi  = '0;
      wild    = '0;
      plen    = 1;
      window  = '0;
      seen    = '0;
      found_q = 1'b0;
      expected_results.delete();
      mismatches_o = 0;
      pending_o    = 0;
      hits_o       = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_PATTERN_LOW:  sig_lo = cfg_i.data;
          CFG_PATTERN_HIGH: sig_hi = cfg_i.data;
          CFG_WILDCARD:     wild = cfg_i.data[MaxPatternBytes-1:0];
          CFG_LENGTH:       plen = cfg_i.data[LenW-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) predict_match(in_i.data_byte, in_i.last_byte);
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none, got match %0b found %0b end %0b", $time,
                   res_i.match_ends_here, res_i.found, res_i.buffer_end);
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("match_ends_here", want.hit, res_i.match_ends_here);
          check_field("found", want.found, res_i.found);
          check_field("buffer_end", want.last, res_i.buffer_end);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: test/tb_wildcard_byte_signature_match_core.sv
`timescale 1ns / 1ps
// Testbench top for the wildcard byte signature matcher: drives byte buffers
// and signature settings, throttles the result side, and gives the verdict.
// Depends on wbsm_pkg, wbsm_if, wbsm_match_checker and the core.
module tb_wildcard_byte_signature_match_core;
  import wbsm_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 90;

  logic clk_i;
  logic rst_ni;

  wbsm_in_if  in_if();
  wbsm_out_if res_if();
  wbsm_cfg_if cfg_if();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned hits;

  wildcard_byte_signature_match_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  wbsm_match_checker match_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .res_i       (res_if),
    .cfg_i       (cfg_if),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .hits_o      (hits)
  );

  bit           steady;
  int unsigned  hold_req;
  int unsigned  cycles;
  int unsigned  bytes_sent;
  int unsigned  buffers_sent;
  int unsigned  settings;
  logic [127:0] sig_now;
  logic [15:0]  mask_now;
  int unsigned  eff_len;
  byte_t        scan_q[$];

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, a no-stall stretch, and long hold-offs on request
  initial begin : res_ready_gen
    int unsigned served;
    int unsigned hold_left;
    served = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != served) begin
        served = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else if (steady) begin
        res_if.ready = 1'b1;
      end else begin
        res_if.ready = ($urandom_range(99) >= 28);
      end
    end
  end

  task automatic send_byte(input byte_t b, input logic last);
    while (!steady && $urandom_range(99) < 28) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data_byte = b;
    in_if.last_byte = last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_scan();
    for (int i = 0; i < scan_q.size(); i++) send_byte(scan_q[i], i == scan_q.size() - 1);
    buffers_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // waits for the block to drain, then loads a new signature
  task automatic program_sig(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] mask_data, input logic [63:0] len_data);
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_WILDCARD, mask_data);
    write_reg(CFG_LENGTH, len_data);
    cfg_if.valid = 1'b0;
    sig_now = {hi, lo};
    mask_now = mask_data[15:0];
    eff_len = len_data[LenW-1:0];
    if (eff_len < 1) eff_len = 1;
    if (eff_len > MaxPatternBytes) eff_len = MaxPatternBytes;
    settings++;
  endtask

  // builds a buffer of n bytes, near-misses drawn from the signature if asked,
  // with whole signature occurrences planted over it
  task automatic fill_scan(input int unsigned n, input int unsigned plants, input bit near);
    int unsigned j;
    int unsigned p;
    scan_q.delete();
    repeat (n) begin
      j = $urandom_range(15);
      scan_q.push_back(near ? sig_now[8*j +: 8] : byte_t'($urandom));
    end
    repeat (plants) begin
      if (n >= eff_len) begin
        p = $urandom_range(n - eff_len);
        for (int k = 0; k < eff_len; k++) begin
          if (!mask_now[k]) scan_q[p+k] = sig_now[8*k +: 8];
        end
      end
    end
  endtask

  initial begin
    logic [63:0] len_data;
    logic [63:0] mask_data;
    int unsigned phase_start;
    int unsigned kind;
    rst_ni = 1'b0;
    steady = 1'b0;
    hold_req = 0;
    cycles = 0;
    bytes_sent = 0;
    buffers_sent = 0;
    settings = 0;
    sig_now = '0;
    mask_now = '0;
    eff_len = 1;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_PATTERN_LOW;
    cfg_if.data = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: one zero byte, found stays sticky then clears at buffer end
    scan_q = '{8'h00, 8'hFF};
    send_scan();
    scan_q = '{8'hFF};
    send_scan();

    // zero length acts as one
    program_sig(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 64'h0);
    scan_q = '{8'hFF, 8'h00, 8'hFF};
    send_scan();

    // overlong length clamps to 16, all wildcards: short buffer, then exact fit
    program_sig(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF);
    scan_q = '{8'h00, 8'hFF};
    send_scan();
    fill_scan(16, 0, 1'b0);
    send_scan();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(7))
        0: len_data = 0;
        1: len_data = 1;
        2: len_data = 16;
        3: len_data = 17;
        4: len_data = 31;
        default: len_data = 64'($urandom_range(16, 1));
      endcase
      if (ph == 0) len_data = 16;
      len_data[63:LenW] = (64 - LenW)'({$urandom, $urandom});
      case ($urandom_range(9))
        0, 1, 2: mask_data = 0;
        3: mask_data = 16'hFFFF;
        default: mask_data = 64'($urandom & $urandom);
      endcase
      if (ph == 0) mask_data = 0;
      mask_data[63:16] = 48'({$urandom, $urandom});
      program_sig({$urandom, $urandom}, {$urandom, $urandom}, mask_data, len_data);
      steady <= (ph == 3);
      if (ph == 5 || ph == 8) hold_req <= hold_req + 1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 43) begin
        kind = $urandom_range(99);
        if (kind < 60) fill_scan(eff_len + $urandom_range(20), $urandom_range(2, 1), 1'b0);
        else if (kind < 75) fill_scan($urandom_range(24, 1), 0, 1'b1);
        else if (kind < 90) fill_scan($urandom_range(30, 1), 0, 1'b0);
        else fill_scan($urandom_range(eff_len, 1), 1, 1'b0);
        send_scan();
      end
    end

    in_if.valid = 1'b0;
    steady <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Scanned %0d bytes in %0d buffers under %0d signature settings,",
             bytes_sent, buffers_sent, settings);
    $display("with %0d match positions and long output hold-offs.", hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/wbsm_pkg.sv
hdl/wbsm_if.sv
hdl/wbsm_match.sv
hdl/wildcard_byte_signature_match_core.sv
hdl/wbsm_checker.sv
test/wbsm_match_checker.sv
test/tb_wildcard_byte_signature_match_core.sv
